// File: design/ille_pkg.sv
// Shared types, codes and constants of the indexed linked-list engine.
// Used by the controller, the datapath, the top level and the checker.
package ille_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 11;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [4:0] dp_op_t;

  localparam dp_op_t DP_NOP    = 5'd0;
  localparam dp_op_t DP_INIT   = 5'd1;
  localparam dp_op_t DP_LOAD   = 5'd2;
  localparam dp_op_t DP_CHECK  = 5'd3;
  localparam dp_op_t DP_WSTEP  = 5'd4;
  localparam dp_op_t DP_WEND   = 5'd5;
  localparam dp_op_t DP_RDV    = 5'd6;
  localparam dp_op_t DP_POP    = 5'd7;
  localparam dp_op_t DP_POPCAP = 5'd8;
  localparam dp_op_t DP_LHEAD  = 5'd9;
  localparam dp_op_t DP_RLINK  = 5'd10;
  localparam dp_op_t DP_LNEW   = 5'd11;
  localparam dp_op_t DP_LPREV  = 5'd12;
  localparam dp_op_t DP_DHEAD  = 5'd13;
  localparam dp_op_t DP_DSEL   = 5'd14;
  localparam dp_op_t DP_RDEL   = 5'd15;
  localparam dp_op_t DP_DLINK  = 5'd16;
  localparam dp_op_t DP_PUSH   = 5'd17;
  localparam dp_op_t DP_OUT    = 5'd18;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             reject;
    logic             head_case;
    logic             pos_zero;
    logic             walk_done;
    logic             init_done;
    logic             out_busy;
  } dp_stat_t;

endpackage

// File: design/ille_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module ille_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/ille_dp.sv
// Datapath of the linked-list engine: node, link and free-stack memories,
// list registers, walk counter and the output register. Uses ille_pkg, ille_ram.
module ille_dp #(
  parameter int CAPACITY = ille_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ille_pkg::dp_ctl_t                   ctl,
  input  logic [ille_pkg::CMD_W-1:0]          in_tuser,
  input  logic [ille_pkg::IN_TDATA_W-1:0]     in_tdata,
  output ille_pkg::dp_stat_t                  stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ille_pkg::STATUS_W-1:0]       out_tuser,
  output logic [ille_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ille_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;
  localparam int PADW = OUT_TDATA_W - VAL_W - LEN_W;

  logic [CMD_W-1:0]    cmd_r;
  logic [POS_W-1:0]    pos_r;
  logic [VAL_W-1:0]    val_r;
  logic [STATUS_W-1:0] status_r;
  logic [SW-1:0]       head_r, cur_r, new_r, del_r;
  logic [LW-1:0]       len_r, ftop_r, cnt_r, init_r;
  logic                follow_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_rd_r;
  logic [LEN_W-1:0]    out_len_r;

  logic              val_we, val_re, link_we, link_re, free_we, free_re;
  logic [SW-1:0]     val_waddr, val_raddr, link_waddr, link_raddr, free_waddr, free_raddr;
  logic [SW-1:0]     link_wdata, free_wdata, link_rdata, free_rdata;
  logic [VAL_W-1:0]  val_rdata;

  logic [CW-1:0]       pos_c, len_c, target_c, len_out_c;
  logic [LW-1:0]       ftop_m1;
  logic [SW-1:0]       cur_eff, link_safe, free_safe;
  logic                full_c;
  logic [STATUS_W-1:0] status_c;

  // A link that points past the store is followed as slot zero.
  function automatic logic [SW-1:0] safe_slot(input logic [SW-1:0] s);
    return (LW'(s) < LW'(CAPACITY)) ? s : '0;
  endfunction

  assign pos_c     = CW'(pos_r);
  assign len_c     = CW'(len_r);
  assign full_c    = (ftop_r == '0);
  assign ftop_m1   = ftop_r - 1'b1;
  assign link_safe = safe_slot(link_rdata);
  assign free_safe = safe_slot(free_rdata);
  assign cur_eff   = follow_r ? link_safe : cur_r;

  always_comb begin
    status_c = ST_OK;
    target_c = '0;
    case (cmd_r)
      CMD_READ: begin
        if (pos_c >= len_c) status_c = ST_RANGE;
        target_c = pos_c;
      end
      CMD_INS_HEAD: begin
        if (full_c) status_c = ST_FULL;
      end
      CMD_INS_TAIL: begin
        if (full_c) status_c = ST_FULL;
        target_c = len_c - 1'b1;
      end
      CMD_INS_POS: begin
        if (pos_c > len_c) status_c = ST_RANGE;
        else if (full_c) status_c = ST_FULL;
        target_c = pos_c - 1'b1;
      end
      CMD_DELETE: begin
        if (pos_c >= len_c) status_c = ST_RANGE;
        target_c = (pos_c == '0) ? '0 : pos_c - 1'b1;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.reject    = (status_c != ST_OK);
  assign stat.head_case = (cmd_r == CMD_INS_HEAD) || (len_r == '0) ||
                          ((cmd_r == CMD_INS_POS) && (pos_r == '0));
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.walk_done = (cnt_r == '0);
  assign stat.init_done = (init_r == LW'(CAPACITY));
  assign stat.out_busy  = out_valid_r && !out_tready;

  // Memory port selection follows the current operation.
  always_comb begin
    val_we = 1'b0;  val_waddr = new_r;  val_re = 1'b0;  val_raddr = cur_r;
    link_we = 1'b0; link_waddr = new_r; link_wdata = head_r;
    link_re = 1'b0; link_raddr = cur_r;
    free_we = 1'b0; free_waddr = init_r[SW-1:0]; free_wdata = init_r[SW-1:0];
    free_re = 1'b0; free_raddr = ftop_m1[SW-1:0];
    case (ctl.op)
      DP_INIT:   free_we = 1'b1;
      DP_WSTEP: begin
        link_re = 1'b1;
        link_raddr = cur_eff;
      end
      DP_RDV:    val_re = 1'b1;
      DP_POP:    free_re = 1'b1;
      DP_POPCAP: begin
        val_we = 1'b1;
        val_waddr = free_safe;
      end
      DP_LHEAD:  link_we = 1'b1;
      DP_RLINK:  link_re = 1'b1;
      DP_LNEW: begin
        link_we = 1'b1;
        link_wdata = link_rdata;
      end
      DP_LPREV: begin
        link_we = 1'b1;
        link_waddr = cur_r;
        link_wdata = new_r;
      end
      DP_RDEL: begin
        link_re = 1'b1;
        link_raddr = del_r;
      end
      DP_DLINK: begin
        link_we = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_rdata;
      end
      DP_PUSH: begin
        free_we = (ftop_r < LW'(CAPACITY));
        free_waddr = ftop_r[SW-1:0];
        free_wdata = del_r;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      len_r       <= '0;
      ftop_r      <= LW'(CAPACITY);
      init_r      <= '0;
      follow_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == DP_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (ctl.op)
        DP_INIT:  init_r <= init_r + 1'b1;
        DP_LOAD: begin
          cmd_r <= in_tuser;
          pos_r <= in_tdata[POS_W-1:0];
          val_r <= in_tdata[POS_W+VAL_W-1:POS_W];
        end
        DP_CHECK: begin
          status_r <= status_c;
          cur_r    <= safe_slot(head_r);
          cnt_r    <= target_c[LW-1:0];
          follow_r <= 1'b0;
        end
        DP_WSTEP: begin
          cur_r    <= cur_eff;
          cnt_r    <= cnt_r - 1'b1;
          follow_r <= 1'b1;
        end
        DP_WEND: begin
          cur_r    <= cur_eff;
          follow_r <= 1'b0;
        end
        DP_POPCAP: begin
          new_r  <= free_safe;
          ftop_r <= ftop_m1;
        end
        DP_LHEAD: begin
          head_r <= new_r;
          len_r  <= len_r + 1'b1;
        end
        DP_LPREV: len_r <= len_r + 1'b1;
        DP_DHEAD: begin
          head_r <= link_rdata;
          del_r  <= cur_r;
          len_r  <= len_r - 1'b1;
        end
        DP_DSEL:  del_r <= link_safe;
        DP_DLINK: len_r <= len_r - 1'b1;
        DP_PUSH: begin
          if (ftop_r < LW'(CAPACITY)) ftop_r <= ftop_r + 1'b1;
        end
        DP_OUT: begin
          out_status_r <= status_r;
          out_rd_r     <= ((cmd_r == CMD_READ) && (status_r == ST_OK)) ? val_rdata : '1;
          out_len_r    <= len_out_c[LEN_W-1:0];
        end
        default: begin
          follow_r <= follow_r;
        end
      endcase
    end
  end

  assign len_out_c = CW'(len_r);

  ille_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_r),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  ille_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  ille_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {PADW'(0), out_len_r, out_rd_r};

endmodule

// File: design/ille_ctrl.sv
// Controller state machine of the linked-list engine; sequences datapath ops.
// Uses ille_pkg.
module ille_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ille_pkg::dp_stat_t  stat,
  output ille_pkg::dp_ctl_t   ctl
);
  import ille_pkg::*;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_POP    = 5'd3;
  localparam logic [4:0] S_POPCAP = 5'd4;
  localparam logic [4:0] S_LHEAD  = 5'd5;
  localparam logic [4:0] S_WALK   = 5'd6;
  localparam logic [4:0] S_RDV    = 5'd7;
  localparam logic [4:0] S_RLINK  = 5'd8;
  localparam logic [4:0] S_LNEW   = 5'd9;
  localparam logic [4:0] S_LPREV  = 5'd10;
  localparam logic [4:0] S_DHEAD  = 5'd11;
  localparam logic [4:0] S_DSEL   = 5'd12;
  localparam logic [4:0] S_RDEL   = 5'd13;
  localparam logic [4:0] S_DLINK  = 5'd14;
  localparam logic [4:0] S_PUSH   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       is_ins;

  assign is_ins = (stat.cmd == CMD_INS_HEAD) || (stat.cmd == CMD_INS_TAIL) ||
                  (stat.cmd == CMD_INS_POS);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = DP_NOP;
    case (state_r)
      S_INIT: begin
        if (stat.init_done) state_nxt = S_IDLE;
        else ctl.op = DP_INIT;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.op = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.op = DP_CHECK;
        if (stat.reject) state_nxt = S_DONE;
        else if (is_ins) state_nxt = S_POP;
        else if ((stat.cmd == CMD_READ) || (stat.cmd == CMD_DELETE)) state_nxt = S_WALK;
        else state_nxt = S_DONE;
      end
      S_POP: begin
        ctl.op = DP_POP;
        state_nxt = S_POPCAP;
      end
      S_POPCAP: begin
        ctl.op = DP_POPCAP;
        state_nxt = stat.head_case ? S_LHEAD : S_WALK;
      end
      S_LHEAD: begin
        ctl.op = DP_LHEAD;
        state_nxt = S_DONE;
      end
      // One link read per cycle until the target slot is reached.
      S_WALK: begin
        if (!stat.walk_done) begin
          ctl.op = DP_WSTEP;
        end else begin
          ctl.op = DP_WEND;
          state_nxt = (stat.cmd == CMD_READ) ? S_RDV : S_RLINK;
        end
      end
      S_RDV: begin
        ctl.op = DP_RDV;
        state_nxt = S_DONE;
      end
      S_RLINK: begin
        ctl.op = DP_RLINK;
        if (is_ins) state_nxt = S_LNEW;
        else if (stat.pos_zero) state_nxt = S_DHEAD;
        else state_nxt = S_DSEL;
      end
      S_LNEW: begin
        ctl.op = DP_LNEW;
        state_nxt = S_LPREV;
      end
      S_LPREV: begin
        ctl.op = DP_LPREV;
        state_nxt = S_DONE;
      end
      S_DHEAD: begin
        ctl.op = DP_DHEAD;
        state_nxt = S_PUSH;
      end
      S_DSEL: begin
        ctl.op = DP_DSEL;
        state_nxt = S_RDEL;
      end
      S_RDEL: begin
        ctl.op = DP_RDEL;
        state_nxt = S_DLINK;
      end
      S_DLINK: begin
        ctl.op = DP_DLINK;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        ctl.op = DP_PUSH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctl.op = DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/indexed_linked_list_engine_core.sv
// Linked-list engine: keeps an ordered list of signed 32-bit values in a node store
// of CAPACITY slots and answers one command per transfer with one result transfer.
// After reset the block fills its free-slot stack and takes no command meanwhile. Refused
// and unused commands and head inserts take no walk; a read, positional insert or delete
// walks the list up to its position and a tail insert up to its length, one link-memory
// read per cycle. Commands are handled one at a time; a finished result waits in the
// output register while the next command is accepted, and a command only stalls at its
// end while the previous result is still waiting there.
module indexed_linked_list_engine_core #(
  parameter int CAPACITY = ille_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ille_pkg::IN_TDATA_W-1:0]  in_tdata,   // position[10:0], value[42:11]
  input  logic [ille_pkg::CMD_W-1:0]       in_tuser,   // command[2:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ille_pkg::OUT_TDATA_W-1:0] out_tdata,  // read_value[31:0], length[42:32]
  output logic [ille_pkg::STATUS_W-1:0]    out_tuser   // status[1:0]
);
  import ille_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  ille_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .ctl(ctl)
  );

  ille_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .stat(stat), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

endmodule

// File: design/ille_chk.sv
// Port-level checker for the linked-list engine, bound to the top level.
// Uses ille_pkg.
module ille_chk #(
  parameter int CAPACITY = ille_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ille_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [ille_pkg::CMD_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ille_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [ille_pkg::STATUS_W-1:0]    out_tuser
);
  import ille_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_RANGE) || (out_tuser == ST_FULL))
    else $error("undefined status code");

  // A refused command never carries read data.
  a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[31:0] == 32'hFFFF_FFFF))
    else $error("rejected command returned data");

  // Each accepted command is answered once, so no new command is taken
  // in the cycle right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in progress");

endmodule

bind indexed_linked_list_engine_core ille_chk #(.CAPACITY(CAPACITY)) u_ille_chk (.*);
